// ===== hw/rtl/srsfe_pkg.sv =====
// ---------------------------------------------------------------------------
// Serial register slave frame engine package
// Shared types, protocol constants and the CRC-16 byte step.
// ---------------------------------------------------------------------------
package srsfe_pkg;

   localparam int FRAME_MAX_DEFAULT = 32;
   // Frame length field wide enough for the largest supported frame store.
   localparam int LEN_W = 7;

   localparam logic [7:0] SLAVE_ADDR_RESET = 8'h0A;
   localparam logic [7:0] FC_READ          = 8'h03;
   localparam logic [7:0] FC_WRITE         = 8'h06;
   localparam logic [7:0] REG_UPS          = 8'h11;
   localparam logic [7:0] REG_LIGHT        = 8'h12;
   localparam logic [7:0] REG_PARK         = 8'h13;
   localparam logic [7:0] REG_BRAKE        = 8'h14;
   localparam logic [7:0] REG_HEIGHT       = 8'h15;
   localparam logic [7:0] REG_LIFT         = 8'h16;
   localparam logic [7:0] NO_LIFT_CMD      = 8'hFF;
   localparam logic [7:0] UPS_RESET        = 8'hFF;

   localparam logic [LEN_W-1:0] MIN_FRAME_LEN = LEN_W'(6);

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   typedef enum logic [2:0] {
      ST_OK,
      ST_SHORT,
      ST_BAD_ADDR,
      ST_BAD_CRC,
      ST_BAD_FUNC,
      ST_OVERFLOW
   } frame_status_type;

   typedef enum logic [2:0] {
      WEV_NONE,
      WEV_UPS,
      WEV_BRAKE,
      WEV_LIGHT,
      WEV_HEIGHT,
      WEV_LIFT
   } write_event_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_APPLY,
      BK_NONE,
      BK_ECHO_RD,
      BK_ECHO_OUT,
      BK_RESP
   } back_state_type;

   typedef struct packed {
      logic [7:0]  rx_byte;
      logic        frame_end;
      logic [7:0]  park_state;
      logic [15:0] current_height;
   } req_type;

   typedef struct packed {
      logic        tx_valid;
      logic [7:0]  tx_byte;
      logic        last_of_run;
      logic [2:0]  frame_status;
      logic [2:0]  write_event;
      logic [7:0]  ups_state;
      logic [7:0]  brake_state;
      logic [31:0] light_word;
      logic [15:0] target_height;
      logic [7:0]  lift_command;
      logic        host_height_mode;
   } rsp_type;

   // One judged frame, handed from the front to the back.
   typedef struct packed {
      logic [2:0]       status;
      logic             is_write;
      logic [7:0]       reg_sel;
      logic [7:0]       addr_byte;
      logic [31:0]      data;
      logic [LEN_W-1:0] len;
      logic             bank;
      logic [7:0]       park_state;
      logic [15:0]      current_height;
   } cmd_type;

   // Read request from the back into the frame store.
   typedef struct packed {
      logic             en;
      logic             bank;
      logic [LEN_W-1:0] idx;
   } rd_req_type;

   function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                              input logic [7:0]  data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int b = 0; b < 8; b++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ===== hw/rtl/srsfe_front.sv =====
// ---------------------------------------------------------------------------
// Frame front end
// Accepts received bytes into a two-bank frame store, keeps a running CRC
// and the header bytes, and judges each frame at its end.
// ---------------------------------------------------------------------------
module srsfe_front #(
   parameter int FRAME_MAX = srsfe_pkg::FRAME_MAX_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  srsfe_pkg::req_type   req_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [7:0]           csr_data,
   input  logic                 fifo_full,
   output logic                 cmd_push,
   output srsfe_pkg::cmd_type   cmd_data,
   input  srsfe_pkg::rd_req_type rd_req,
   output logic [7:0]           rd_data
);

   localparam int CNT_W  = $clog2(FRAME_MAX + 1);
   localparam int ADDR_W = $clog2(FRAME_MAX);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(FRAME_MAX);

   logic [7:0]       mem_ff [2][FRAME_MAX];
   logic [7:0]       rd_data_ff;

   logic [CNT_W-1:0] byte_count_ff, byte_count_in;
   logic             overflow_ff, overflow_in;
   logic             bank_ff, bank_in;
   logic [7:0]       slave_addr_ff, slave_addr_in;
   logic [15:0]      crc_cur_ff, crc_cur_in;
   logic [15:0]      crc_d1_ff, crc_d1_in;
   logic [7:0]       last_byte_ff, last_byte_in;
   logic [7:0]       hdr_ff [3];
   logic [7:0]       hdr_in [3];
   logic [7:0]       dat_ff [4];
   logic [7:0]       dat_in [4];

   logic                       accept;
   logic                       stored;
   logic [srsfe_pkg::LEN_W-1:0] frame_len;
   logic [7:0]                 data_sel [4];
   srsfe_pkg::frame_status_type status;

   assign full      = fifo_full;
   assign csr_ready = 1'b1;
   assign rd_data   = rd_data_ff;

   always_comb begin
      accept    = push & ~fifo_full;
      stored    = byte_count_ff < CNT_MAX;
      frame_len = srsfe_pkg::LEN_W'(byte_count_ff) + srsfe_pkg::LEN_W'(stored);

      // The closing byte may itself be one of the write data bytes.
      for (int i = 0; i < 4; i++) begin
         data_sel[i] = (byte_count_ff == CNT_W'(3 + i)) ? req_data.rx_byte : dat_ff[i];
      end

      priority if (overflow_ff || !stored) begin
         status = srsfe_pkg::ST_OVERFLOW;
      end else if (frame_len < srsfe_pkg::MIN_FRAME_LEN) begin
         status = srsfe_pkg::ST_SHORT;
      end else if (hdr_ff[0] != slave_addr_ff) begin
         status = srsfe_pkg::ST_BAD_ADDR;
      end else if (crc_d1_ff != {req_data.rx_byte, last_byte_ff}) begin
         status = srsfe_pkg::ST_BAD_CRC;
      end else if (hdr_ff[1] != srsfe_pkg::FC_READ && hdr_ff[1] != srsfe_pkg::FC_WRITE) begin
         status = srsfe_pkg::ST_BAD_FUNC;
      end else begin
         status = srsfe_pkg::ST_OK;
      end

      cmd_push                = accept & req_data.frame_end;
      cmd_data.status         = status;
      cmd_data.is_write       = hdr_ff[1] == srsfe_pkg::FC_WRITE;
      cmd_data.reg_sel        = hdr_ff[2];
      cmd_data.addr_byte      = hdr_ff[0];
      cmd_data.data           = {data_sel[0], data_sel[1], data_sel[2], data_sel[3]};
      cmd_data.len            = frame_len;
      cmd_data.bank           = bank_ff;
      cmd_data.park_state     = req_data.park_state;
      cmd_data.current_height = req_data.current_height;

      byte_count_in = byte_count_ff;
      overflow_in   = overflow_ff;
      bank_in       = bank_ff;
      crc_cur_in    = crc_cur_ff;
      crc_d1_in     = crc_d1_ff;
      last_byte_in  = last_byte_ff;
      hdr_in        = hdr_ff;
      dat_in        = dat_ff;
      slave_addr_in = csr_valid ? csr_data : slave_addr_ff;

      if (accept) begin
         if (stored) begin
            byte_count_in = byte_count_ff + CNT_W'(1);
            crc_d1_in     = crc_cur_ff;
            crc_cur_in    = srsfe_pkg::crc16_byte(crc_cur_ff, req_data.rx_byte);
            last_byte_in  = req_data.rx_byte;
            for (int i = 0; i < 3; i++) begin
               if (byte_count_ff == CNT_W'(i)) begin
                  hdr_in[i] = req_data.rx_byte;
               end
            end
            dat_in = data_sel;
         end else begin
            overflow_in = 1'b1;
         end
         if (req_data.frame_end) begin
            byte_count_in = '0;
            overflow_in   = 1'b0;
            bank_in       = ~bank_ff;
            crc_cur_in    = srsfe_pkg::CRC_INIT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
         overflow_ff   <= 1'b0;
         bank_ff       <= 1'b0;
         slave_addr_ff <= srsfe_pkg::SLAVE_ADDR_RESET;
         crc_cur_ff    <= srsfe_pkg::CRC_INIT;
      end else begin
         byte_count_ff <= byte_count_in;
         overflow_ff   <= overflow_in;
         bank_ff       <= bank_in;
         slave_addr_ff <= slave_addr_in;
         crc_cur_ff    <= crc_cur_in;
      end
   end

   always_ff @(posedge clock) begin
      crc_d1_ff    <= crc_d1_in;
      last_byte_ff <= last_byte_in;
      hdr_ff       <= hdr_in;
      dat_ff       <= dat_in;
   end

   // Frame store: one write port for the front, one registered read port
   // for the back. The back always reads the other bank than the one filling.
   always_ff @(posedge clock) begin
      if (accept && stored) begin
         mem_ff[bank_ff][byte_count_ff[ADDR_W-1:0]] <= req_data.rx_byte;
      end
      if (rd_req.en) begin
         rd_data_ff <= mem_ff[rd_req.bank][rd_req.idx[ADDR_W-1:0]];
      end
   end

endmodule

// ===== hw/rtl/srsfe_cmd_fifo.sv =====
// ---------------------------------------------------------------------------
// Frame command queue
// Two-entry queue of judged frames between the front and the back.
// ---------------------------------------------------------------------------
module srsfe_cmd_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  srsfe_pkg::cmd_type push_data,
   input  logic               pop,
   output srsfe_pkg::cmd_type head,
   output logic               head_valid,
   output logic               full
);

   srsfe_pkg::cmd_type entry_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;

   assign head       = entry_ff[rd_ptr_ff];
   assign head_valid = count_ff != 2'd0;
   assign full       = count_ff == 2'd2;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/srsfe_back.sv =====
// ---------------------------------------------------------------------------
// Frame back end
// Holds the control registers, applies writes, and sends the echo, the
// read response or a single status beat through the output register.
// ---------------------------------------------------------------------------
module srsfe_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cmd_valid,
   input  srsfe_pkg::cmd_type    cmd_data,
   output logic                  cmd_pop,
   output srsfe_pkg::rd_req_type rd_req,
   input  logic [7:0]            rd_data,
   output logic                  empty,
   input  logic                  pop,
   output srsfe_pkg::rsp_type    rsp_data
);

   localparam int LEN_W = srsfe_pkg::LEN_W;

   srsfe_pkg::back_state_type  state_ff, state_in;
   srsfe_pkg::write_event_type wev_ff, wev_in;
   logic [LEN_W-1:0]           idx_ff, idx_in;
   logic [15:0]                crc_ff, crc_in;
   logic [31:0]                pl_ff, pl_in;
   logic [2:0]                 plen_ff, plen_in;

   logic [7:0]                 ups_ff, ups_in;
   logic [7:0]                 brake_ff, brake_in;
   logic [31:0]                light_ff, light_in;
   logic [15:0]                target_ff, target_in;
   logic [7:0]                 lift_ff, lift_in;
   logic                       host_ff, host_in;

   logic                       out_valid_ff, out_valid_in;
   srsfe_pkg::rsp_type         out_ff, out_in;

   logic                       slot_free;
   logic [2:0]                 rd_plen;
   logic [31:0]                rd_pl;
   logic [LEN_W-1:0]           pay_end;
   logic [7:0]                 resp_byte;
   logic                       emit;
   logic                       emit_valid;
   logic [7:0]                 emit_byte;
   logic                       emit_last;

   assign empty    = ~out_valid_ff;
   assign rsp_data = out_ff;

   // Read payload: registers as they are, or the frame's park/height.
   always_comb begin
      rd_plen = 3'd0;
      rd_pl   = '0;
      unique case (cmd_data.reg_sel)
         srsfe_pkg::REG_UPS: begin
            rd_plen = 3'd1;
            rd_pl   = {ups_ff, 24'h0};
         end
         srsfe_pkg::REG_LIGHT: begin
            rd_plen = 3'd4;
            rd_pl   = light_ff;
         end
         srsfe_pkg::REG_PARK: begin
            rd_plen = 3'd1;
            rd_pl   = {cmd_data.park_state, 24'h0};
         end
         srsfe_pkg::REG_BRAKE: begin
            rd_plen = 3'd1;
            rd_pl   = {brake_ff, 24'h0};
         end
         srsfe_pkg::REG_HEIGHT: begin
            rd_plen = 3'd2;
            rd_pl   = {cmd_data.current_height, 16'h0};
         end
         srsfe_pkg::REG_LIFT: begin
            rd_plen = 3'd1;
            rd_pl   = {lift_ff, 24'h0};
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      pay_end = LEN_W'(plen_ff) + LEN_W'(3);
      priority if (idx_ff == LEN_W'(0)) begin
         resp_byte = cmd_data.addr_byte;
      end else if (idx_ff == LEN_W'(1)) begin
         resp_byte = srsfe_pkg::FC_READ;
      end else if (idx_ff == LEN_W'(2)) begin
         resp_byte = {5'b0, plen_ff};
      end else if (idx_ff < pay_end) begin
         resp_byte = pl_ff[31:24];
      end else if (idx_ff == pay_end) begin
         resp_byte = crc_ff[7:0];
      end else begin
         resp_byte = crc_ff[15:8];
      end
   end

   always_comb begin
      slot_free  = ~out_valid_ff | pop;
      state_in   = state_ff;
      wev_in     = wev_ff;
      idx_in     = idx_ff;
      crc_in     = crc_ff;
      pl_in      = pl_ff;
      plen_in    = plen_ff;
      ups_in     = ups_ff;
      brake_in   = brake_ff;
      light_in   = light_ff;
      target_in  = target_ff;
      lift_in    = lift_ff;
      host_in    = host_ff;
      cmd_pop    = 1'b0;
      rd_req     = '0;
      emit       = 1'b0;
      emit_valid = 1'b1;
      emit_byte  = 8'h00;
      emit_last  = 1'b0;

      unique case (state_ff)
         srsfe_pkg::BK_IDLE: begin
            if (cmd_valid) begin
               state_in = srsfe_pkg::BK_APPLY;
            end
         end
         srsfe_pkg::BK_APPLY: begin
            idx_in  = '0;
            crc_in  = srsfe_pkg::CRC_INIT;
            wev_in  = srsfe_pkg::WEV_NONE;
            pl_in   = rd_pl;
            plen_in = rd_plen;
            if (cmd_data.status != srsfe_pkg::ST_OK) begin
               state_in = srsfe_pkg::BK_NONE;
            end else if (cmd_data.is_write) begin
               state_in = srsfe_pkg::BK_ECHO_RD;
               unique case (cmd_data.reg_sel)
                  srsfe_pkg::REG_UPS: begin
                     ups_in = cmd_data.data[31:24];
                     wev_in = srsfe_pkg::WEV_UPS;
                  end
                  srsfe_pkg::REG_BRAKE: begin
                     brake_in = cmd_data.data[31:24];
                     wev_in   = srsfe_pkg::WEV_BRAKE;
                  end
                  srsfe_pkg::REG_LIGHT: begin
                     light_in = cmd_data.data;
                     wev_in   = srsfe_pkg::WEV_LIGHT;
                  end
                  srsfe_pkg::REG_HEIGHT: begin
                     target_in = cmd_data.data[31:16];
                     lift_in   = srsfe_pkg::NO_LIFT_CMD;
                     host_in   = 1'b1;
                     wev_in    = srsfe_pkg::WEV_HEIGHT;
                  end
                  srsfe_pkg::REG_LIFT: begin
                     lift_in = cmd_data.data[31:24];
                     host_in = 1'b1;
                     wev_in  = srsfe_pkg::WEV_LIFT;
                  end
                  default: begin
                  end
               endcase
            end else if (rd_plen == 3'd0) begin
               state_in = srsfe_pkg::BK_NONE;
            end else begin
               state_in = srsfe_pkg::BK_RESP;
            end
         end
         srsfe_pkg::BK_NONE: begin
            if (slot_free) begin
               emit       = 1'b1;
               emit_valid = 1'b0;
               emit_last  = 1'b1;
               cmd_pop    = 1'b1;
               state_in   = srsfe_pkg::BK_IDLE;
            end
         end
         srsfe_pkg::BK_ECHO_RD: begin
            rd_req.en   = 1'b1;
            rd_req.bank = cmd_data.bank;
            rd_req.idx  = idx_ff;
            state_in    = srsfe_pkg::BK_ECHO_OUT;
         end
         srsfe_pkg::BK_ECHO_OUT: begin
            if (slot_free) begin
               emit      = 1'b1;
               emit_byte = rd_data;
               emit_last = idx_ff == cmd_data.len - LEN_W'(1);
               idx_in    = idx_ff + LEN_W'(1);
               if (emit_last) begin
                  cmd_pop  = 1'b1;
                  state_in = srsfe_pkg::BK_IDLE;
               end else begin
                  state_in = srsfe_pkg::BK_ECHO_RD;
               end
            end
         end
         srsfe_pkg::BK_RESP: begin
            if (slot_free) begin
               emit      = 1'b1;
               emit_byte = resp_byte;
               emit_last = idx_ff == pay_end + LEN_W'(1);
               idx_in    = idx_ff + LEN_W'(1);
               if (idx_ff < pay_end) begin
                  crc_in = srsfe_pkg::crc16_byte(crc_ff, resp_byte);
               end
               if (idx_ff >= LEN_W'(3) && idx_ff < pay_end) begin
                  pl_in = pl_ff << 8;
               end
               if (emit_last) begin
                  cmd_pop  = 1'b1;
                  state_in = srsfe_pkg::BK_IDLE;
               end
            end
         end
         default: begin
            state_in = srsfe_pkg::BK_IDLE;
         end
      endcase

      out_in                  = out_ff;
      out_in.tx_valid         = emit_valid;
      out_in.tx_byte          = emit_byte;
      out_in.last_of_run      = emit_last;
      out_in.frame_status     = cmd_data.status;
      out_in.write_event      = wev_ff;
      out_in.ups_state        = ups_ff;
      out_in.brake_state      = brake_ff;
      out_in.light_word       = light_ff;
      out_in.target_height    = target_ff;
      out_in.lift_command     = lift_ff;
      out_in.host_height_mode = host_ff;
      if (!emit) begin
         out_in = out_ff;
      end

      if (emit) begin
         out_valid_in = 1'b1;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= srsfe_pkg::BK_IDLE;
         out_valid_ff <= 1'b0;
         ups_ff       <= srsfe_pkg::UPS_RESET;
         brake_ff     <= '0;
         light_ff     <= '0;
         target_ff    <= '0;
         lift_ff      <= srsfe_pkg::NO_LIFT_CMD;
         host_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         ups_ff       <= ups_in;
         brake_ff     <= brake_in;
         light_ff     <= light_in;
         target_ff    <= target_in;
         lift_ff      <= lift_in;
         host_ff      <= host_in;
      end
   end

   always_ff @(posedge clock) begin
      wev_ff  <= wev_in;
      idx_ff  <= idx_in;
      crc_ff  <= crc_in;
      pl_ff   <= pl_in;
      plen_ff <= plen_in;
      out_ff  <= out_in;
   end

endmodule

// ===== hw/rtl/serial_register_slave_frame_engine.sv =====
// ---------------------------------------------------------------------------
// Serial register slave frame engine
// Collects received frame bytes, checks length, address, CRC-16 and
// function, applies register writes and sends echo or read responses.
//
//   channel   handshake          payload
//   request   push / full        req_data  (srsfe_pkg::req_type)
//   response  pop / empty        rsp_data  (srsfe_pkg::rsp_type)
//   config    csr_valid / ready  csr_data  (slave address)
//
// Bytes are taken while full is low. At a frame end the back starts on the
// judged frame; each echoed byte is read from the frame store (one read
// port, registered) first; read response bytes come from the registers.
// The front keeps taking bytes of the next frame while the back works,
// up to one judged frame waiting in the command queue; then full rises.
// A stalled response beat holds in the output register. Reset is
// synchronous and needs no clearing pass.
// ---------------------------------------------------------------------------
module serial_register_slave_frame_engine #(
   parameter int FRAME_MAX = srsfe_pkg::FRAME_MAX_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  srsfe_pkg::req_type req_data,
   output logic               empty,
   input  logic               pop,
   output srsfe_pkg::rsp_type rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [7:0]         csr_data
);

   logic                  fifo_full;
   logic                  cmd_push;
   srsfe_pkg::cmd_type    cmd_in;
   srsfe_pkg::cmd_type    cmd_head;
   logic                  cmd_valid;
   logic                  cmd_pop;
   srsfe_pkg::rd_req_type rd_req;
   logic [7:0]            rd_data;

   srsfe_front #(
      .FRAME_MAX (FRAME_MAX)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .fifo_full (fifo_full),
      .cmd_push  (cmd_push),
      .cmd_data  (cmd_in),
      .rd_req    (rd_req),
      .rd_data   (rd_data)
   );

   srsfe_cmd_fifo u_cmd_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (cmd_push),
      .push_data  (cmd_in),
      .pop        (cmd_pop),
      .head       (cmd_head),
      .head_valid (cmd_valid),
      .full       (fifo_full)
   );

   srsfe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_head),
      .cmd_pop   (cmd_pop),
      .rd_req    (rd_req),
      .rd_data   (rd_data),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data)
   );

   // A status-only beat always closes its frame and carries no byte.
   assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_data.tx_valid) |-> (rsp_data.last_of_run && rsp_data.tx_byte == 8'h00))
      else $error("status-only beat is not a clean closing beat");

   // A rejected frame never sends bytes.
   assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.frame_status != srsfe_pkg::ST_OK) |-> !rsp_data.tx_valid)
      else $error("response byte sent for a rejected frame");

   // A register write only happens for a good frame, which is echoed.
   assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.write_event != srsfe_pkg::WEV_NONE)
         |-> (rsp_data.frame_status == srsfe_pkg::ST_OK && rsp_data.tx_valid))
      else $error("write event reported without an echoed good frame");

   // The back only pops a queued frame.
   assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid)
      else $error("command queue popped while empty");

endmodule
